/* rtl/lru_pkg.sv */
// ----------------------------------------------------------------------------
// lru_pkg
// Shared sizes, command codes and control types of the LRU replacement tracker.
// ----------------------------------------------------------------------------
package lru_pkg;

  // store geometry
  localparam int NUM_BLOCKS = 16;
  localparam int IDX_W      = 4;
  localparam int RANK_W     = IDX_W;
  localparam int LIMIT_W    = RANK_W + 1;
  localparam int CMD_W      = 2;

  // command codes of the input word
  localparam logic [CMD_W-1:0] CMD_REPLACE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACCESS  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INVAL   = 2'd2;

  // status codes of the result word
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the input word
    logic search;  // pick the block and the aging limit
    logic update;  // apply the recency update and launch the result
  } lru_ctl_t;

endpackage

/* rtl/lru_ctrl.sv */
// ----------------------------------------------------------------------------
// lru_ctrl
// Sequencer of the tracker: accept, search, update, one word at a time.
// ----------------------------------------------------------------------------
module lru_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output lru_pkg::lru_ctl_t ctl
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_SEARCH;
      ST_SEARCH: state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands to the datapath
  assign busy       = (state_r != ST_IDLE);
  assign ctl.load   = (state_r == ST_IDLE) && start;
  assign ctl.search = (state_r == ST_SEARCH);
  assign ctl.update = (state_r == ST_UPDATE);

`ifndef SYNTH
  // an accepted word keeps the block busy through the search and update states
  a_busy_span: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy ##1 busy ##1 !busy)
    else $error("busy span after accept is wrong");

  // search always follows a load
  a_search_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> ctl.search)
    else $error("search did not follow load");
`endif

endmodule

/* rtl/lru_dp.sv */
// ----------------------------------------------------------------------------
// lru_dp
// Valid marks, recency ranks, block selection and result registers.
// ----------------------------------------------------------------------------
module lru_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lru_pkg::lru_ctl_t           ctl,
  input  logic [lru_pkg::CMD_W-1:0]   in_cmd,
  input  logic [lru_pkg::IDX_W-1:0]   in_block_index,
  output logic                        out_valid,
  output logic [lru_pkg::IDX_W-1:0]   out_chosen_block,
  output logic                        out_from_free,
  output logic                        out_status
);

  localparam int N = lru_pkg::NUM_BLOCKS;
  localparam logic [lru_pkg::RANK_W-1:0] RANK_OLDEST = lru_pkg::RANK_W'(N - 1);

  // captured input word
  logic [lru_pkg::CMD_W-1:0]   op_r;
  logic [lru_pkg::IDX_W-1:0]   idx_r;

  // tracker state
  logic [N-1:0]                valid_r;
  logic [lru_pkg::RANK_W-1:0]  rank_r [N];

  // search results
  logic [lru_pkg::IDX_W-1:0]   chosen_r, chosen_nxt;
  logic                        free_r, free_nxt;
  logic                        status_r, status_nxt;
  logic [lru_pkg::LIMIT_W-1:0] limit_r, limit_nxt;
  logic                        upd_r, upd_nxt;
  logic                        clr_r, clr_nxt;

  // result registers
  logic                        out_valid_r;
  logic [lru_pkg::IDX_W-1:0]   out_chosen_r;
  logic                        out_free_r;
  logic                        out_status_r;
  logic [lru_pkg::CMD_W-1:0]   out_op_r;

  logic                        has_free;
  logic [lru_pkg::IDX_W-1:0]   free_idx;
  logic [lru_pkg::IDX_W-1:0]   lru_idx;

  // capture the word on accept
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r  <= in_cmd;
      idx_r <= in_block_index;
    end
  end

  // lowest invalid block and the oldest valid block
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    lru_idx  = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        has_free = 1'b1;
        free_idx = lru_pkg::IDX_W'(i);
      end
      if (valid_r[i] && (rank_r[i] == RANK_OLDEST)) begin
        lru_idx = lru_pkg::IDX_W'(i);
      end
    end
  end

  // decide block, flags and aging limit
  always_comb begin
    chosen_nxt = idx_r;
    free_nxt   = 1'b0;
    status_nxt = lru_pkg::STATUS_OK;
    limit_nxt  = '0;
    upd_nxt    = 1'b0;
    clr_nxt    = 1'b0;
    unique case (op_r)
      lru_pkg::CMD_REPLACE: begin
        upd_nxt = 1'b1;
        if (has_free) begin
          chosen_nxt = free_idx;
          free_nxt   = 1'b1;
          limit_nxt  = lru_pkg::LIMIT_W'(N);
        end else begin
          chosen_nxt = lru_idx;
          limit_nxt  = {1'b0, rank_r[lru_idx]};
        end
      end
      lru_pkg::CMD_ACCESS: begin
        if (valid_r[idx_r]) begin
          upd_nxt   = 1'b1;
          limit_nxt = {1'b0, rank_r[idx_r]};
        end else begin
          status_nxt = lru_pkg::STATUS_INVALID;
        end
      end
      lru_pkg::CMD_INVAL: begin
        clr_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.search) begin
      chosen_r <= chosen_nxt;
      free_r   <= free_nxt;
      status_r <= status_nxt;
      limit_r  <= limit_nxt;
      upd_r    <= upd_nxt;
      clr_r    <= clr_nxt;
    end
  end

  // recency update and invalidate-all
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < N; i++) begin
        rank_r[i] <= '0;
      end
    end else if (ctl.update) begin
      if (clr_r) begin
        valid_r <= '0;
        for (int i = 0; i < N; i++) begin
          rank_r[i] <= '0;
        end
      end else if (upd_r) begin
        for (int i = 0; i < N; i++) begin
          if (lru_pkg::IDX_W'(i) == chosen_r) begin
            rank_r[i]  <= '0;
            valid_r[i] <= 1'b1;
          end else if (valid_r[i] && ({1'b0, rank_r[i]} < limit_r)) begin
            rank_r[i] <= rank_r[i] + 1'b1;
          end
        end
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.update;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (ctl.update) begin
      out_chosen_r <= chosen_r;
      out_free_r   <= free_r;
      out_status_r <= status_r;
      out_op_r     <= op_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_block = out_chosen_r;
  assign out_from_free    = out_free_r;
  assign out_status       = out_status_r;

`ifndef SYNTH
  // a block handed out from the free pool is valid afterwards
  a_free_now_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_from_free) |-> valid_r[out_chosen_block])
    else $error("freshly allocated block is not valid");

  // the chosen block of a replace or good access is the most recent
  a_chosen_mru: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == lru_pkg::STATUS_OK) &&
     ((out_op_r == lru_pkg::CMD_REPLACE) || (out_op_r == lru_pkg::CMD_ACCESS)))
    |-> (rank_r[out_chosen_block] == '0))
    else $error("chosen block is not most recent");

  // invalidate-all leaves no valid block
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_op_r == lru_pkg::CMD_INVAL)) |-> (valid_r == '0))
    else $error("valid marks survive invalidate-all");
`endif

endmodule

/* rtl/lru_replacement_tracker.sv */
// A command accepted in idle passes through the search and update states over
// the rank registers; its result strobe is registered from the update state,
// and the result is on the out_ ports for one cycle. Busy is high from accept
// until the update is done, and a new command is taken only back in idle.
// Reset: synchronous, active low; all blocks invalid, ranks zero, no result.
// ----------------------------------------------------------------------------
// lru_replacement_tracker
// LRU replacement tracker for a fully associative store of sixteen blocks.
// ----------------------------------------------------------------------------
module lru_replacement_tracker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [lru_pkg::CMD_W-1:0]   in_cmd,
  input  logic [lru_pkg::IDX_W-1:0]   in_block_index,
  output logic                        out_valid,
  output logic [lru_pkg::IDX_W-1:0]   out_chosen_block,
  output logic                        out_from_free,
  output logic                        out_status
);

  lru_pkg::lru_ctl_t ctl;

  // sequencer
  lru_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  // state and selection
  lru_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .in_cmd           (in_cmd),
    .in_block_index   (in_block_index),
    .out_valid        (out_valid),
    .out_chosen_block (out_chosen_block),
    .out_from_free    (out_from_free),
    .out_status       (out_status)
  );

endmodule

/* test/tb_lru_replacement_tracker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_replacement_tracker
// Self-checking bench for the LRU replacement tracker. A queue of command
// words, directed first and random after, feeds a falling-edge driver; a
// rising-edge monitor predicts each accepted word against a shadow copy of
// the valid marks and age ranks and checks every result word in order.
// ----------------------------------------------------------------------------
module tb_lru_replacement_tracker;

  localparam logic [lru_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1000;
  localparam int QUIET_TAIL   = 150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE       = 10;

  typedef struct packed {
    logic [lru_pkg::CMD_W-1:0] cmd;
    logic [lru_pkg::IDX_W-1:0] idx;
    logic                      drain;  // hold off until every result is back
  } cmd_word_t;

  typedef struct packed {
    logic [lru_pkg::IDX_W-1:0] chosen;
    logic                      from_free;
    logic                      status;
  } lru_result_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [lru_pkg::CMD_W-1:0] in_cmd = '0;
  logic [lru_pkg::IDX_W-1:0] in_block_index = '0;
  logic                      out_valid;
  logic [lru_pkg::IDX_W-1:0] out_chosen_block;
  logic                      out_from_free;
  logic                      out_status;

  lru_replacement_tracker u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_block_index   (in_block_index),
    .out_valid        (out_valid),
    .out_chosen_block (out_chosen_block),
    .out_from_free    (out_from_free),
    .out_status       (out_status)
  );

  // shadow of the tracker state
  logic [lru_pkg::RANK_W-1:0] age_rank[lru_pkg::NUM_BLOCKS];
  logic                       blk_valid[lru_pkg::NUM_BLOCKS];
  logic [lru_pkg::IDX_W:0]    blocks_used;

  cmd_word_t   cmd_words[$];
  lru_result_t lru_results[$];
  cmd_word_t   next_word;
  logic        word_taken = 1'b0;
  int          idle_left = 0;
  int          words_total = 0;
  int          words_taken = 0;
  int          errors = 0;
  int          cycle_cnt = 0;
  int          gen_fill = 0;  // valid blocks are always 0 .. gen_fill-1

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
  end

  // clear all valid marks and ranks
  function automatic void clear_tracker();
    for (int i = 0; i < lru_pkg::NUM_BLOCKS; i++) begin
      age_rank[i]  = '0;
      blk_valid[i] = 1'b0;
    end
    blocks_used = '0;
  endfunction

  // block b becomes youngest; valid blocks younger than limit age by one
  function automatic void promote_block(int b, int limit);
    for (int i = 0; i < lru_pkg::NUM_BLOCKS; i++) begin
      if (i != b && blk_valid[i] && age_rank[i] < limit)
        age_rank[i] = age_rank[i] + 1'b1;
    end
    age_rank[b] = '0;
  endfunction

  // expected result of one command word, updating the shadow state
  function automatic lru_result_t predict_lru(logic [lru_pkg::CMD_W-1:0] cmd,
                                              logic [lru_pkg::IDX_W-1:0] idx);
    lru_result_t r;
    int          victim;
    int          oldest;
    bit          found;
    r.chosen    = idx;
    r.from_free = 1'b0;
    r.status    = lru_pkg::STATUS_OK;
    victim      = 0;
    oldest      = -1;
    found       = 1'b0;
    case (cmd)
      lru_pkg::CMD_REPLACE: begin
        for (int i = 0; i < lru_pkg::NUM_BLOCKS; i++) begin
          if (!found && !blk_valid[i]) begin
            found  = 1'b1;
            victim = i;
          end
        end
        if (found) begin
          promote_block(victim, 256);
          blk_valid[victim] = 1'b1;
          if (blocks_used < lru_pkg::NUM_BLOCKS) blocks_used = blocks_used + 1'b1;
          r.from_free = 1'b1;
        end else begin
          // evict the oldest, lowest index on a tie
          for (int i = 0; i < lru_pkg::NUM_BLOCKS; i++) begin
            if (blk_valid[i] && int'(age_rank[i]) > oldest) begin
              victim = i;
              oldest = age_rank[i];
            end
          end
          promote_block(victim, oldest);
        end
        r.chosen = lru_pkg::IDX_W'(victim);
      end
      lru_pkg::CMD_ACCESS: begin
        if (int'(idx) < lru_pkg::NUM_BLOCKS && blk_valid[idx])
          promote_block(idx, age_rank[idx]);
        else
          r.status = lru_pkg::STATUS_INVALID;
      end
      lru_pkg::CMD_INVAL: begin
        clear_tracker();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // queue one word and track which blocks it leaves valid
  function automatic void queue_word(logic [lru_pkg::CMD_W-1:0] cmd,
                                     logic [lru_pkg::IDX_W-1:0] idx,
                                     logic drain);
    cmd_word_t w;
    w.cmd   = cmd;
    w.idx   = idx;
    w.drain = drain;
    cmd_words.push_back(w);
    words_total++;
    if (cmd == lru_pkg::CMD_REPLACE && gen_fill < lru_pkg::NUM_BLOCKS) gen_fill++;
    if (cmd == lru_pkg::CMD_INVAL) gen_fill = 0;
  endfunction

  // stimulus: directed corners, then mostly legal traffic with some noise
  initial begin
    int pick;
    clear_tracker();
    queue_word(lru_pkg::CMD_ACCESS, 4'd15, 1'b0);  // access on empty store
    queue_word(CMD_UNUSED, 4'd15, 1'b0);
    queue_word(lru_pkg::CMD_INVAL, 4'd10, 1'b0);
    for (int i = 0; i < lru_pkg::NUM_BLOCKS; i++)
      queue_word(lru_pkg::CMD_REPLACE, lru_pkg::IDX_W'($urandom_range(0, 15)), 1'b0);
    queue_word(lru_pkg::CMD_REPLACE, 4'd0, 1'b0);  // first eviction
    queue_word(lru_pkg::CMD_ACCESS, 4'd5, 1'b0);
    queue_word(lru_pkg::CMD_ACCESS, 4'd15, 1'b0);
    queue_word(lru_pkg::CMD_REPLACE, 4'd15, 1'b0);
    queue_word(CMD_UNUSED, 4'd0, 1'b0);
    queue_word(lru_pkg::CMD_INVAL, 4'd5, 1'b1);
    queue_word(lru_pkg::CMD_ACCESS, 4'd0, 1'b0);   // access after invalidate
    queue_word(lru_pkg::CMD_REPLACE, 4'd7, 1'b0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        queue_word(lru_pkg::CMD_INVAL, lru_pkg::IDX_W'($urandom_range(0, 15)),
                   n % 250 == 100);
      end else if (pick < 5) begin
        queue_word(CMD_UNUSED, lru_pkg::IDX_W'($urandom_range(0, 15)),
                   n % 250 == 100);
      end else if (pick < 10 && gen_fill < lru_pkg::NUM_BLOCKS) begin
        queue_word(lru_pkg::CMD_ACCESS, lru_pkg::IDX_W'($urandom_range(gen_fill, 15)),
                   n % 250 == 100);
      end else if (pick < 55 && gen_fill > 0) begin
        queue_word(lru_pkg::CMD_ACCESS, lru_pkg::IDX_W'($urandom_range(0, gen_fill - 1)),
                   n % 250 == 100);
      end else begin
        queue_word(lru_pkg::CMD_REPLACE, lru_pkg::IDX_W'($urandom_range(0, 15)),
                   n % 250 == 100);
      end
    end

    // all words in, all results back, then a quiet spell
    while (words_taken < words_total || lru_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // driver: hold a word until taken, else idle or offer the next word
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !word_taken) begin
      end else if (idle_left > 0) begin
        start     <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (cmd_words.size() == 0) begin
        start <= 1'b0;
      end else if (cmd_words[0].drain && lru_results.size() != 0) begin
        start <= 1'b0;
      end else if (cmd_words.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        start     <= 1'b0;
        idle_left <= $urandom_range(0, 17);
      end else begin
        next_word = cmd_words.pop_front();
        start          <= 1'b1;
        in_cmd         <= next_word.cmd;
        in_block_index <= next_word.idx;
      end
    end
  end

  // monitor: check result words, then predict the word taken at this edge
  always @(posedge clk) begin
    lru_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (lru_results.size() == 0) begin
          $error("result word with none expected: chosen_block %0d", out_chosen_block);
          errors++;
        end else begin
          want = lru_results.pop_front();
          if (out_chosen_block !== want.chosen) begin
            $error("chosen_block expected %0d actual %0d", want.chosen, out_chosen_block);
            errors++;
          end
          if (out_from_free !== want.from_free) begin
            $error("from_free expected %0d actual %0d", want.from_free, out_from_free);
            errors++;
          end
          if (out_status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_status);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        lru_results.push_back(predict_lru(in_cmd, in_block_index));
        words_taken++;
      end
    end
    word_taken <= rst_n && start && !busy;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
